### src/fcv_pkg.sv
// ----------------------------------------------------------------------------
// fcv_pkg
// Shared types and constants for the full linear convolution block.
// ----------------------------------------------------------------------------
package fcv_pkg;

    // Exact Q7.30 accumulator width of one convolution output
    localparam int SUM_W     = 37;
    // Width of the kernel length register
    localparam int CFG_W     = 6;
    // Width of the tap index field
    localparam int TAP_IDX_W = 5;

    // Operation codes carried by an input item
    localparam logic OP_TAP    = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_EMIT
    } fcv_state_t;

endpackage

### src/fcv_in_if.sv
// ----------------------------------------------------------------------------
// fcv_in_if
// Input channel: kernel tap loads and signal samples.
// ----------------------------------------------------------------------------
interface fcv_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                                valid;
    logic                                ready;
    logic                                op;
    logic [fcv_pkg::TAP_IDX_W-1:0]       tap_index;
    logic signed [SAMPLE_BITS-1:0]       value;
    logic                                last_sample;

    modport source (output valid, op, tap_index, value, last_sample, input ready);
    modport sink   (input valid, op, tap_index, value, last_sample, output ready);
endinterface

### src/fcv_cfg_if.sv
// ----------------------------------------------------------------------------
// fcv_cfg_if
// Configuration write channel for the kernel length register.
// ----------------------------------------------------------------------------
interface fcv_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [fcv_pkg::CFG_W-1:0]     data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### src/fcv_out_if.sv
// ----------------------------------------------------------------------------
// fcv_out_if
// Output channel: convolution outputs with end-of-frame flag.
// ----------------------------------------------------------------------------
interface fcv_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [fcv_pkg::SUM_W-1:0]  conv_sum;
    logic                              end_of_frame;

    modport source (output valid, conv_sum, end_of_frame, input ready);
    modport sink   (input valid, conv_sum, end_of_frame, output ready);
endinterface

### src/full_linear_convolution.sv
// ----------------------------------------------------------------------------
// full_linear_convolution
// Direct-form full linear convolution of a streamed signal with a kernel.
// ----------------------------------------------------------------------------
// Load the kernel first: each op-0 item writes one Q1.15 tap. Each op-1
// item is a signal sample; it yields one exact 37-bit Q7.30 output, the sum
// over j < l of tap[j] * history[j] with history[0] the new sample. The
// sample flagged last_sample also yields the l-1 tail outputs (zeros shifted
// in), the final one carrying end_of_frame, after which the history reads as
// zero again. l is kernel_length clamped to 1..MAX_TAPS and is taken when the
// sample is accepted. One shared multiply-accumulate walks the taps through
// the single read port of each memory: for each sample and each tail output
// it issues the l taps in turn, drains its pipeline and then loads the output
// register, and no new item is taken until then. The output register lets
// the next item in while a result waits to be taken; the block stalls only
// if a new output is ready before the previous one has left. No clearing
// pass is needed after reset.
// ----------------------------------------------------------------------------
module full_linear_convolution #(
    parameter int MAX_TAPS    = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    fcv_cfg_if.sink   cfg,
    fcv_in_if.sink    din,
    fcv_out_if.source dout
);

    // Address width of both memories; history depth is the next power of two
    localparam int IDX_W      = $clog2(MAX_TAPS);
    localparam int HIST_DEPTH = 1 << IDX_W;
    // Wide enough to hold MAX_TAPS itself
    localparam int LEN_W      = $clog2(MAX_TAPS + 1);
    localparam int PROD_W     = 2 * SAMPLE_BITS;
    localparam int SUM_W      = fcv_pkg::SUM_W;

    // ------------------------------------------------------------------
    // Storage
    // ------------------------------------------------------------------
    // Kernel taps: undefined until written, no valid bits.
    logic signed [SAMPLE_BITS-1:0] tap_mem  [MAX_TAPS];
    // Sample history as a circular buffer; wp_reg points at the newest.
    // Entries at distance >= hist_fill_reg from it read as zero.
    logic signed [SAMPLE_BITS-1:0] hist_mem [HIST_DEPTH];

    fcv_pkg::fcv_state_t state_reg, state_next;

    logic [fcv_pkg::CFG_W-1:0]     kernel_length_reg;
    logic [LEN_W-1:0]              len_reg;         // l latched per sample
    logic [LEN_W-1:0]              rem_reg;         // tail outputs still due
    logic                          frame_last_reg;  // current sample ends frame
    logic [LEN_W-1:0]              hist_fill_reg;   // valid history depth
    logic [IDX_W-1:0]              wp_reg;
    logic [IDX_W-1:0]              j_reg;           // tap being issued

    // MAC pipeline
    logic                          s1_vld_reg;
    logic                          s1_hv_reg;
    logic signed [SAMPLE_BITS-1:0] tap_q_reg;
    logic signed [SAMPLE_BITS-1:0] hist_q_reg;
    logic                          s2_vld_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [SUM_W-1:0]       acc_reg;

    // Output register
    logic                          out_valid_reg;
    logic signed [SUM_W-1:0]       out_sum_reg;
    logic                          out_eof_reg;

    // ------------------------------------------------------------------
    // Control decode
    // ------------------------------------------------------------------
    logic                  in_ready;
    logic                  push_sample;
    logic                  load_tap;
    logic                  slot_free;
    logic                  emit;
    logic                  push_zero;
    logic                  issue;
    logic                  last_issue;
    logic                  drained;
    logic                  frame_done;
    logic [LEN_W-1:0]      len_calc;
    logic [LEN_W-1:0]      len_m1;
    logic [IDX_W-1:0]      wp_inc;
    logic [IDX_W-1:0]      hist_raddr;
    logic signed [SAMPLE_BITS-1:0] hist_op;

    // Clamp kernel length to 1..MAX_TAPS
    always_comb
    begin
        if (kernel_length_reg == '0)
        begin
            len_calc = LEN_W'(1);
        end
        else if (32'(kernel_length_reg) > MAX_TAPS)
        begin
            len_calc = LEN_W'(MAX_TAPS);
        end
        else
        begin
            len_calc = LEN_W'(kernel_length_reg);
        end
    end

    assign len_m1     = len_reg - LEN_W'(1);
    assign wp_inc     = wp_reg + IDX_W'(1);
    assign hist_raddr = wp_reg - j_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            fcv_pkg::ST_IDLE:
            begin
                if (push_sample)
                begin
                    state_next = fcv_pkg::ST_MAC;
                end
            end
            fcv_pkg::ST_MAC:
            begin
                if (last_issue)
                begin
                    state_next = fcv_pkg::ST_DRAIN;
                end
            end
            fcv_pkg::ST_DRAIN:
            begin
                if (drained)
                begin
                    state_next = fcv_pkg::ST_EMIT;
                end
            end
            fcv_pkg::ST_EMIT:
            begin
                if (emit)
                begin
                    state_next = push_zero ? fcv_pkg::ST_MAC : fcv_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = fcv_pkg::ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        in_ready    = (state_reg == fcv_pkg::ST_IDLE);
        push_sample = in_ready && din.valid && (din.op == fcv_pkg::OP_SAMPLE);
        load_tap    = in_ready && din.valid && (din.op == fcv_pkg::OP_TAP);
        slot_free   = !out_valid_reg || dout.ready;
        emit        = (state_reg == fcv_pkg::ST_EMIT) && slot_free;
        push_zero   = emit && (rem_reg != '0);
        frame_done  = emit && (rem_reg == '0) && frame_last_reg;
        issue       = (state_reg == fcv_pkg::ST_MAC);
        last_issue  = issue && (j_reg == IDX_W'(len_m1));
        drained     = (state_reg == fcv_pkg::ST_DRAIN) && !s1_vld_reg && !s2_vld_reg;
    end

    assign din.ready = in_ready;
    assign cfg.ready = 1'b1;

    // ------------------------------------------------------------------
    // Memories
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (load_tap && (32'(din.tap_index) < MAX_TAPS))
        begin
            tap_mem[IDX_W'(din.tap_index)] <= din.value;
        end
        tap_q_reg <= tap_mem[j_reg];
    end

    always_ff @(posedge clk)
    begin
        if (push_sample)
        begin
            hist_mem[wp_inc] <= din.value;
        end
        else if (push_zero)
        begin
            hist_mem[wp_inc] <= '0;
        end
        hist_q_reg <= hist_mem[hist_raddr];
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= fcv_pkg::ST_IDLE;
            kernel_length_reg <= fcv_pkg::CFG_W'(1);
            len_reg           <= LEN_W'(1);
            rem_reg           <= '0;
            frame_last_reg    <= 1'b0;
            hist_fill_reg     <= '0;
            wp_reg            <= '0;
            j_reg             <= '0;
            s1_vld_reg        <= 1'b0;
            s2_vld_reg        <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg.valid)
            begin
                kernel_length_reg <= cfg.data;
            end

            if (push_sample)
            begin
                len_reg        <= len_calc;
                rem_reg        <= din.last_sample ? (len_calc - LEN_W'(1)) : '0;
                frame_last_reg <= din.last_sample;
            end
            else if (push_zero)
            begin
                rem_reg <= rem_reg - LEN_W'(1);
            end

            if (push_sample || push_zero)
            begin
                wp_reg <= wp_inc;
                j_reg  <= '0;
                if (32'(hist_fill_reg) < MAX_TAPS)
                begin
                    hist_fill_reg <= hist_fill_reg + LEN_W'(1);
                end
            end
            else
            begin
                if (issue && !last_issue)
                begin
                    j_reg <= j_reg + IDX_W'(1);
                end
                // End of frame: history reads as zero from here on
                if (frame_done)
                begin
                    hist_fill_reg <= '0;
                end
            end

            s1_vld_reg <= issue;
            s2_vld_reg <= s1_vld_reg;

            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (dout.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // MAC datapath
    // ------------------------------------------------------------------
    always_comb
    begin
        hist_op = hist_q_reg;
        if (!s1_hv_reg)
        begin
            hist_op = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_hv_reg <= (LEN_W'(j_reg) < hist_fill_reg);
        prod_reg  <= tap_q_reg * hist_op;
        if (push_sample || push_zero)
        begin
            acc_reg <= '0;
        end
        else if (s2_vld_reg)
        begin
            acc_reg <= acc_reg + SUM_W'(prod_reg);
        end
        if (emit)
        begin
            out_sum_reg <= acc_reg;
            out_eof_reg <= frame_last_reg && (rem_reg == '0);
        end
    end

    assign dout.valid        = out_valid_reg;
    assign dout.conv_sum     = out_sum_reg;
    assign dout.end_of_frame = out_eof_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    // A sample starts a computation, so the next cycle cannot take an item
    a_sample_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        push_sample |=> !din.ready)
        else $error("input taken while a sample is being computed");

    // The issue index never reaches the latched length
    a_issue_range: assert property (@(posedge clk) disable iff (!rst_n)
        issue |-> (LEN_W'(j_reg) < len_reg))
        else $error("tap index past kernel length");

    // Products only reach the accumulator while a sum is being built
    a_pipe_state: assert property (@(posedge clk) disable iff (!rst_n)
        s2_vld_reg |-> (state_reg == fcv_pkg::ST_MAC || state_reg == fcv_pkg::ST_DRAIN))
        else $error("product in flight outside accumulation");

    // Tail outputs are only owed on the last sample of a frame
    a_tail_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rem_reg != '0) |-> frame_last_reg)
        else $error("tail outputs pending without last sample");
`endif

endmodule

### test/fcv_conv_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fcv_conv_checker
// Watches the configuration, input and output channels of the convolution
// block, keeps its own copy of kernel and history, predicts every output and
// compares it field by field with what the block emits.
// ----------------------------------------------------------------------------
module fcv_conv_checker #(
    parameter int MAX_TAPS    = 32,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [fcv_pkg::CFG_W-1:0]        cfg_data,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic                             in_op,
    input  logic [fcv_pkg::TAP_IDX_W-1:0]    in_tap_index,
    input  logic signed [SAMPLE_BITS-1:0]    in_value,
    input  logic                             in_last,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic signed [fcv_pkg::SUM_W-1:0] out_conv_sum,
    input  logic                             out_end_of_frame,
    output int                               error_count,
    output int                               outstanding
);

    typedef struct packed {
        logic signed [fcv_pkg::SUM_W-1:0] conv_sum;
        logic                             end_of_frame;
    } conv_out_t;

    logic [fcv_pkg::CFG_W-1:0]     kernel_len;
    logic signed [SAMPLE_BITS-1:0] kernel [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] history [MAX_TAPS];
    conv_out_t                     conv_expected_q [$];
    conv_out_t                     want;
    int                            taps_used;
    int                            n_out;
    int                            k;

    // kernel length as the block applies it: 0 reads as 1, saturates at MAX_TAPS
    function automatic int taps_in_force();
        if (kernel_len == 0)
            return 1;
        if (kernel_len > MAX_TAPS)
            return MAX_TAPS;
        return int'(kernel_len);
    endfunction

    // shift one sample into the history, return the exact dot product
    function automatic logic signed [fcv_pkg::SUM_W-1:0] shift_and_accumulate(
        input logic signed [SAMPLE_BITS-1:0] x,
        input int                            len
    );
        longint acc;
        int     j;
        acc = 0;
        for (j = MAX_TAPS - 1; j > 0; j--)
            history[j] = history[j-1];
        history[0] = x;
        for (j = 0; j < len; j++)
            acc += longint'(kernel[j]) * longint'(history[j]);
        return acc[fcv_pkg::SUM_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_len = 1;
            foreach (history[i])
                history[i] = '0;
            conv_expected_q.delete();
            error_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                kernel_len = cfg_data;

            if (out_valid && out_ready)
            begin
                if (conv_expected_q.size() == 0)
                begin
                    $display("%0t: unexpected item: expected none, actual conv_sum %0d eof %0b",
                             $time, out_conv_sum, out_end_of_frame);
                    error_count++;
                end
                else
                begin
                    want = conv_expected_q.pop_front();
                    if (out_conv_sum !== want.conv_sum)
                    begin
                        $display("%0t: conv_sum mismatch: expected %0d, actual %0d",
                                 $time, $signed(want.conv_sum), out_conv_sum);
                        error_count++;
                    end
                    if (out_end_of_frame !== want.end_of_frame)
                    begin
                        $display("%0t: end_of_frame mismatch: expected %0b, actual %0b",
                                 $time, want.end_of_frame, out_end_of_frame);
                        error_count++;
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                if (in_op == fcv_pkg::OP_TAP)
                begin
                    if (in_tap_index < MAX_TAPS)
                        kernel[in_tap_index] = in_value;
                end
                else
                begin
                    taps_used = taps_in_force();
                    n_out     = in_last ? taps_used : 1;
                    for (k = 0; k < n_out; k++)
                    begin
                        want.conv_sum     = shift_and_accumulate((k == 0) ? in_value : '0,
                                                                 taps_used);
                        want.end_of_frame = in_last && (k == n_out - 1);
                        conv_expected_q.push_back(want);
                    end
                    if (in_last)
                        foreach (history[i])
                            history[i] = '0;
                end
            end

            outstanding = conv_expected_q.size();
        end
    end

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top level for the full linear convolution block: directed and random
// stimulus over several kernel lengths and idling patterns; a side checker
// predicts and compares every output item.
// ----------------------------------------------------------------------------
module tb;

    localparam int MAX_TAPS      = 32;
    localparam int SAMPLE_BITS   = 16;
    localparam int RESET_CYCLES  = 12;
    // twice the worst single computation
    localparam int DRAIN_CYCLES  = 2 * (MAX_TAPS + 5);
    localparam int HOLD_CYCLES   = 400;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 26;
    localparam int CYCLE_LIMIT   = 1_500_000;

    localparam logic signed [SAMPLE_BITS-1:0] VAL_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] VAL_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

    typedef enum int {
        IDLE_NONE,
        IDLE_SENDER,
        IDLE_RECEIVER,
        IDLE_BOTH
    } idle_mode_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    fcv_cfg_if                             cfg_if ();
    fcv_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) din_if ();
    fcv_out_if                             dout_if ();

    int                  error_count;
    int                  outstanding;
    int                  send_idle_pct  = 0;
    int                  recv_stall_pct = 0;
    logic                hold_req       = 1'b0;
    int                  hold_cnt       = 0;
    logic                hold_taken     = 1'b0;
    int                  cycle_count    = 0;
    // taps written so far; a length is only applied once its taps are loaded
    logic [MAX_TAPS-1:0] tap_loaded     = '0;

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    full_linear_convolution #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .din   (din_if),
        .dout  (dout_if)
    );

    fcv_conv_checker #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) i_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_if.valid),
        .cfg_ready        (cfg_if.ready),
        .cfg_data         (cfg_if.data),
        .in_valid         (din_if.valid),
        .in_ready         (din_if.ready),
        .in_op            (din_if.op),
        .in_tap_index     (din_if.tap_index),
        .in_value         (din_if.value),
        .in_last          (din_if.last_sample),
        .out_valid        (dout_if.valid),
        .out_ready        (dout_if.ready),
        .out_conv_sum     (dout_if.conv_sum),
        .out_end_of_frame (dout_if.end_of_frame),
        .error_count      (error_count),
        .outstanding      (outstanding)
    );

    // Receiver: random back-pressure, plus one long hold-off on request so
    // that the output register fills and the block stalls its input.
    initial
    begin
        dout_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_cnt != 0)
            begin
                hold_cnt      = hold_cnt - 1;
                dout_if.ready <= 1'b0;
            end
            else if (hold_req && !hold_taken)
            begin
                hold_cnt      = HOLD_CYCLES;
                hold_taken    = 1'b1;
                dout_if.ready <= 1'b0;
            end
            else
                dout_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL full_linear_convolution");
        $finish;
    end

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE:     begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin send_idle_pct = 86; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin send_idle_pct = 0;  recv_stall_pct = 86; end
            default:       begin send_idle_pct = 21; recv_stall_pct = 21; end
        endcase
    endtask

    // Mostly random, with the extremes and zero weighted up
    function automatic logic signed [SAMPLE_BITS-1:0] rand_value();
        int r;
        r = $urandom_range(15);
        if (r == 0)
            return VAL_MIN;
        if (r == 1)
            return VAL_MAX;
        if (r == 2)
            return '0;
        return SAMPLE_BITS'($urandom);
    endfunction

    // Offer one item, with an optional random gap first; returns once it has
    // been taken. valid stays high into the next item when there is no gap.
    task automatic push_item(
        input logic                            op,
        input logic [fcv_pkg::TAP_IDX_W-1:0]   idx,
        input logic signed [SAMPLE_BITS-1:0]   val,
        input logic                            last
    );
        if ($urandom_range(99) < send_idle_pct)
        begin
            din_if.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
        din_if.valid       <= 1'b1;
        din_if.op          <= op;
        din_if.tap_index   <= idx;
        din_if.value       <= val;
        din_if.last_sample <= last;
        @(posedge clk);
        while (!din_if.ready)
            @(posedge clk);
        if (op == fcv_pkg::OP_TAP)
            tap_loaded[idx] = 1'b1;
    endtask

    // All outputs in, then room for a tap load or computation still in flight
    task automatic wait_drained();
        din_if.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // Write the kernel length while idle, then load any taps it would read
    // that have never been written.
    task automatic write_length(input logic [fcv_pkg::CFG_W-1:0] len);
        int active;
        int j;
        wait_drained();
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= len;
        @(posedge clk);
        while (!cfg_if.ready)
            @(posedge clk);
        cfg_if.valid <= 1'b0;
        active = (len == 0) ? 1 : (len > MAX_TAPS) ? MAX_TAPS : int'(len);
        for (j = 0; j < active; j++)
            if (!tap_loaded[j])
                push_item(fcv_pkg::OP_TAP, fcv_pkg::TAP_IDX_W'(j), rand_value(), 1'b0);
    endtask

    // Frames of random length with random content; tap reloads land at
    // random, often in mid-frame.
    task automatic run_random_phase(input int items);
        int n;
        int frame_left;
        frame_left = $urandom_range(10, 1);
        for (n = 0; n < items; n++)
        begin
            if ($urandom_range(99) < 15)
                push_item(fcv_pkg::OP_TAP, fcv_pkg::TAP_IDX_W'($urandom),
                          rand_value(), 1'($urandom));
            else
            begin
                frame_left--;
                push_item(fcv_pkg::OP_SAMPLE, fcv_pkg::TAP_IDX_W'($urandom),
                          rand_value(), frame_left == 0);
                if (frame_left == 0)
                    frame_left = ($urandom_range(3) == 0) ? 1 : $urandom_range(12, 1);
            end
        end
    endtask

    initial
    begin : stimulus
        int                           p;
        int                           j;
        logic [fcv_pkg::CFG_W-1:0]    len;

        // Known values on every input from time zero
        cfg_if.valid       = 1'b0;
        cfg_if.data        = '0;
        din_if.valid       = 1'b0;
        din_if.op          = fcv_pkg::OP_TAP;
        din_if.tap_index   = '0;
        din_if.value       = '0;
        din_if.last_sample = 1'b0;
        set_idling(IDLE_NONE);

        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed part ----
        // four taps: both extremes, -1 and 1; last_sample on a tap load has no effect
        push_item(fcv_pkg::OP_TAP, 5'd0, VAL_MIN, 1'b1);
        push_item(fcv_pkg::OP_TAP, 5'd1, VAL_MAX, 1'b0);
        push_item(fcv_pkg::OP_TAP, 5'd2, -16'sd1, 1'b0);
        push_item(fcv_pkg::OP_TAP, 5'd3, 16'sd1,  1'b0);
        write_length(6'd4);

        // one frame of extreme samples: five direct outputs plus a tail of three
        push_item(fcv_pkg::OP_SAMPLE, 5'd0,  VAL_MIN, 1'b0);
        push_item(fcv_pkg::OP_SAMPLE, 5'd31, VAL_MAX, 1'b0);
        push_item(fcv_pkg::OP_SAMPLE, 5'd0,  16'sd0,  1'b0);
        push_item(fcv_pkg::OP_SAMPLE, 5'd0,  -16'sd1, 1'b0);
        push_item(fcv_pkg::OP_SAMPLE, 5'd0,  VAL_MIN, 1'b1);
        // single-sample frame: history must read as zero again
        push_item(fcv_pkg::OP_SAMPLE, 5'd0,  VAL_MAX, 1'b1);

        // length zero behaves as a single tap
        write_length(6'd0);
        push_item(fcv_pkg::OP_SAMPLE, 5'd0, VAL_MIN, 1'b1);
        push_item(fcv_pkg::OP_SAMPLE, 5'd0, 16'sd1,  1'b0);
        push_item(fcv_pkg::OP_SAMPLE, 5'd0, -16'sd1, 1'b1);

        // length changed in mid-frame: history carries over
        write_length(6'd2);
        push_item(fcv_pkg::OP_SAMPLE, 5'd0, 16'sd5,  1'b0);
        write_length(6'd3);
        push_item(fcv_pkg::OP_SAMPLE, 5'd0, -16'sd7, 1'b1);

        // tap reload in mid-frame
        push_item(fcv_pkg::OP_SAMPLE, 5'd0, 16'sd100, 1'b0);
        push_item(fcv_pkg::OP_TAP,    5'd1, VAL_MIN,  1'b0);
        push_item(fcv_pkg::OP_SAMPLE, 5'd0, 16'sd200, 1'b1);

        // ---- largest sums, oversized length, long receiver hold-off ----
        for (j = 0; j < MAX_TAPS; j++)
            push_item(fcv_pkg::OP_TAP, fcv_pkg::TAP_IDX_W'(j), VAL_MIN, 1'b0);
        write_length({fcv_pkg::CFG_W{1'b1}});
        hold_req <= 1'b1;
        for (j = 0; j < 20; j++)
            push_item(fcv_pkg::OP_SAMPLE, 5'd0, (j < 10) ? VAL_MIN : VAL_MAX, j == 19);
        hold_req <= 1'b0;

        // ---- random part: one kernel length and idling pattern per phase ----
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0:       len = 6'd1;
                1:       len = 6'd33;
                2:       len = fcv_pkg::CFG_W'($urandom_range(6, 2));
                3:       len = 6'd0;
                4:       len = 6'd32;
                5:       len = fcv_pkg::CFG_W'($urandom_range(12, 1));
                6:       len = fcv_pkg::CFG_W'($urandom_range(31, 1));
                default: len = fcv_pkg::CFG_W'($urandom_range(63, 34));
            endcase
            write_length(len);
            set_idling(idle_mode_t'(p % 4));
            run_random_phase(PHASE_ITEMS);
        end

        wait_drained();
        if (error_count == 0)
            $display("PASS full_linear_convolution");
        else
            $display("FAIL full_linear_convolution");
        $finish;
    end

endmodule

### filelist.f
src/fcv_pkg.sv
src/fcv_in_if.sv
src/fcv_cfg_if.sv
src/fcv_out_if.sv
src/full_linear_convolution.sv
test/fcv_conv_checker.sv
test/tb.sv
